@@ src/assert_macros.svh @@
// Assertion helpers used by the RTL controller. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define EKH_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define EKH_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define EKH_ASSERT(lbl, clk, rst, prop, msg)

`define EKH_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

@@ src/ekh_pkg.sv @@
package ekh_pkg;

  localparam int OP_W      = 2;
  localparam int ROW_W     = 3;
  localparam int COL_W     = 4;
  localparam int IN_SMP_W  = 12;
  localparam int CFG_W     = 12;
  localparam int LVL_W     = 13;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [CFG_W-1:0] RST_LOW_FLOOR         = 12'd300;
  localparam logic [CFG_W-1:0] RST_HIGH_FLOOR        = 12'd1000;
  localparam logic [CFG_W-1:0] RST_RELEASE_DEFAULT   = 12'd500;
  localparam logic [CFG_W-1:0] RST_ACTUATION_DEFAULT = 12'd550;
  localparam logic [CFG_W-1:0] RST_ACT_MARGIN        = 12'd70;
  localparam logic [CFG_W-1:0] RST_REL_MARGIN        = 12'd50;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE    = 2'd0,
    OP_RECOMPUTE = 2'd1,
    OP_DEFAULTS  = 2'd2
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW_FLOOR         = 3'd0,
    REG_HIGH_FLOOR        = 3'd1,
    REG_RELEASE_DEFAULT   = 3'd2,
    REG_ACTUATION_DEFAULT = 3'd3,
    REG_ACT_MARGIN        = 3'd4,
    REG_REL_MARGIN        = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_RECOMPUTE,
    MODE_DEFAULTS,
    MODE_RESET
  } sweep_mode_t;

  typedef enum logic [1:0] {
    EMIT_KEY,
    EMIT_ECHO,
    EMIT_ZERO
  } emit_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] low_floor;
    logic [CFG_W-1:0] high_floor;
    logic [CFG_W-1:0] release_default;
    logic [CFG_W-1:0] actuation_default;
    logic [CFG_W-1:0] act_margin;
    logic [CFG_W-1:0] rel_margin;
  } cfg_t;

  typedef struct packed {
    logic        capture;
    logic        rd_en;
    logic        rd_sweep;
    logic        calc;
    logic        sample_wr;
    logic        sweep_wr;
    sweep_mode_t mode;
    logic        out_load;
    emit_kind_t  kind;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_range;
    logic            out_free;
  } sts_t;

endpackage

@@ src/ekh_req_if.sv @@
interface ekh_req_if import ekh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ROW_W-1:0]    key_row;
  logic [COL_W-1:0]    key_col;
  logic [IN_SMP_W-1:0] sample;
  logic                tune_enable;

  modport source (output valid, op, key_row, key_col, sample, tune_enable, input ready);
  modport sink (input valid, op, key_row, key_col, sample, tune_enable, output ready);
endinterface

@@ src/ekh_rsp_if.sv @@
interface ekh_rsp_if import ekh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             pressed;
  logic             changed;

  modport source (output valid, out_row, out_col, pressed, changed, input ready);
  modport sink (input valid, out_row, out_col, pressed, changed, output ready);
endinterface

@@ src/ekh_regs.sv @@
module ekh_regs import ekh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_t               cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_floor         <= RST_LOW_FLOOR;
      cfg.high_floor        <= RST_HIGH_FLOOR;
      cfg.release_default   <= RST_RELEASE_DEFAULT;
      cfg.actuation_default <= RST_ACTUATION_DEFAULT;
      cfg.act_margin        <= RST_ACT_MARGIN;
      cfg.rel_margin        <= RST_REL_MARGIN;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOW_FLOOR:         cfg.low_floor         <= pwdata[CFG_W-1:0];
        REG_HIGH_FLOOR:        cfg.high_floor        <= pwdata[CFG_W-1:0];
        REG_RELEASE_DEFAULT:   cfg.release_default   <= pwdata[CFG_W-1:0];
        REG_ACTUATION_DEFAULT: cfg.actuation_default <= pwdata[CFG_W-1:0];
        REG_ACT_MARGIN:        cfg.act_margin        <= pwdata[CFG_W-1:0];
        REG_REL_MARGIN:        cfg.rel_margin        <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOW_FLOOR:         prdata = PDATA_W'(cfg.low_floor);
      REG_HIGH_FLOOR:        prdata = PDATA_W'(cfg.high_floor);
      REG_RELEASE_DEFAULT:   prdata = PDATA_W'(cfg.release_default);
      REG_ACTUATION_DEFAULT: prdata = PDATA_W'(cfg.actuation_default);
      REG_ACT_MARGIN:        prdata = PDATA_W'(cfg.act_margin);
      REG_REL_MARGIN:        prdata = PDATA_W'(cfg.rel_margin);
      default:               prdata = '0;
    endcase
  end

endmodule

@@ src/ekh_ctrl.sv @@
`include "assert_macros.svh"

module ekh_ctrl import ekh_pkg::*; #(
  parameter int NKEYS = 128
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    req_valid,
  output logic                                    req_ready,
  input  sts_t                                    sts,
  output cmd_t                                    cmd,
  output logic [((NKEYS > 1) ? $clog2(NKEYS) : 1)-1:0] sweep_addr
);

  localparam int AW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int CNT_W = $clog2(NKEYS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CALC,
    ST_WRITE,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  state_t          state;
  logic [CNT_W-1:0] cnt;
  sweep_mode_t     mode;
  emit_kind_t      kind;
  logic            cnt_done;

  assign cnt_done   = (cnt == CNT_W'(NKEYS));
  assign sweep_addr = cnt[AW-1:0];

  always_comb begin
    req_ready     = 1'b0;
    cmd           = '0;
    cmd.mode      = mode;
    cmd.kind      = kind;
    case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_DISPATCH: begin
        cmd.rd_en = (sts.op == OP_SAMPLE) && sts.in_range;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
      end
      ST_WRITE: begin
        cmd.sample_wr = 1'b1;
        cmd.out_load  = sts.out_free;
        cmd.kind      = EMIT_KEY;
      end
      ST_SWEEP: begin
        // read one key ahead of the write-back
        cmd.rd_en    = !cnt_done;
        cmd.rd_sweep = 1'b1;
        cmd.sweep_wr = (cnt != '0);
      end
      ST_EMIT: begin
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      cnt   <= '0;
      mode  <= MODE_RESET;
      kind  <= EMIT_ZERO;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          cnt <= '0;
          case (sts.op)
            OP_SAMPLE: begin
              if (sts.in_range) begin
                state <= ST_CALC;
              end else begin
                kind  <= EMIT_ECHO;
                state <= ST_EMIT;
              end
            end
            OP_RECOMPUTE: begin
              mode  <= MODE_RECOMPUTE;
              state <= ST_SWEEP;
            end
            OP_DEFAULTS: begin
              mode  <= MODE_DEFAULTS;
              state <= ST_SWEEP;
            end
            default: begin
              kind  <= EMIT_ZERO;
              state <= ST_EMIT;
            end
          endcase
        end
        ST_CALC: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          kind <= EMIT_KEY;
          if (sts.out_free) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_SWEEP: begin
          if (cnt_done) begin
            kind <= EMIT_ZERO;
            // the power-up pass reports nothing
            if (mode == MODE_RESET) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_EMIT;
            end
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `EKH_ASSERT(a_busy_after_accept, clk, rst, (req_valid && req_ready) |=> !req_ready, "accepted while busy")
  `EKH_ASSERT_NEVER(a_one_writer, clk, rst, cmd.sample_wr && cmd.sweep_wr, "two memory writers")
  `EKH_ASSERT(a_load_when_free, clk, rst, cmd.out_load |-> sts.out_free, "result overwritten")
  `EKH_ASSERT(a_calc_then_write, clk, rst, cmd.calc |=> cmd.sample_wr, "calc not written back")

endmodule

@@ src/ekh_dp.sv @@
module ekh_dp import ekh_pkg::*; #(
  parameter int ROWS        = 8,
  parameter int COLS        = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  cfg_t                                          cfg,
  input  cmd_t                                          cmd,
  input  logic [((ROWS*COLS > 1) ? $clog2(ROWS*COLS) : 1)-1:0] sweep_addr,
  output sts_t                                          sts,
  input  logic [OP_W-1:0]                               req_op,
  input  logic [ROW_W-1:0]                              req_row,
  input  logic [COL_W-1:0]                              req_col,
  input  logic [IN_SMP_W-1:0]                           req_sample,
  input  logic                                          req_tune,
  output logic                                          rsp_valid,
  input  logic                                          rsp_ready,
  output logic [ROW_W-1:0]                              rsp_row,
  output logic [COL_W-1:0]                              rsp_col,
  output logic                                          rsp_pressed,
  output logic                                          rsp_changed
);

  localparam int NKEYS = ROWS * COLS;
  localparam int AW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int SB    = SAMPLE_BITS;
  localparam int XW    = SB + 4;
  localparam int PW    = 2 * XW;
  localparam int CMP_W = (SB > LVL_W) ? SB : LVL_W;
  localparam int SW    = ((SB > CFG_W) ? SB : CFG_W) + 1;
  localparam logic [XW-1:0] RECIP   = XW'((64'd1 << XW) / 64'd10);
  localparam logic [XW-1:0] DIVISOR = XW'(10);

  typedef struct packed {
    logic             pressed;
    logic [SB-1:0]    tuned_low;
    logic [SB-1:0]    tuned_high;
    logic [LVL_W-1:0] act_level;
    logic [LVL_W-1:0] rel_level;
  } key_word_t;

  key_word_t mem [NKEYS];
  key_word_t rdata;
  key_word_t wdata;
  key_word_t calc_word;
  key_word_t calc_next;
  key_word_t samp_word;
  key_word_t sweep_word;

  logic [OP_W-1:0]  op_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [SB-1:0]    v_q;
  logic             tune_q;

  logic [31:0]   key_full;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_addr_q;

  logic [CMP_W-1:0] v_c, hi_c, hf_c, lf_c, rdf_c, act_c, rel_c;
  logic             hi_hit, lo_hit, up_hi, up_lo;
  logic [SB:0]      hi_sum;
  logic [XW-1:0]    x_next, x_q;
  logic [PW-1:0]    prod_q;
  logic             lo_upd_q;
  logic             changed_next, changed_q;

  logic [XW-1:0] q0, ten_q0, rem, q_fix;

  logic [SW-1:0] lo_s, sum_act, sum_rel;
  logic          recomp_ok;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= req_op;
      row_q  <= req_row;
      col_q  <= req_col;
      v_q    <= SB'(req_sample);
      tune_q <= req_tune;
    end
  end

  assign key_full     = 32'(row_q) * 32'(COLS) + 32'(col_q);
  assign sts.op       = op_q;
  assign sts.in_range = (32'(row_q) < 32'(ROWS)) && (32'(col_q) < 32'(COLS));
  assign sts.out_free = !rsp_valid || rsp_ready;

  assign rd_addr = cmd.rd_sweep ? sweep_addr : key_full[AW-1:0];

  // key table, read one entry and write one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (cmd.sample_wr || cmd.sweep_wr) begin
      mem[rd_addr_q] <= wdata;
    end
  end

  // tuning and hysteresis on the entry just read
  always_comb begin
    v_c   = CMP_W'(v_q);
    hi_c  = CMP_W'(rdata.tuned_high);
    hf_c  = CMP_W'(cfg.high_floor);
    lf_c  = CMP_W'(cfg.low_floor);
    rdf_c = CMP_W'(cfg.release_default);
    act_c = CMP_W'(rdata.act_level);
    rel_c = CMP_W'(rdata.rel_level);

    hi_hit = (v_c > hi_c) && (v_c > hf_c);
    lo_hit = (v_c > lf_c) && (v_c < rdf_c);
    up_hi  = tune_q && hi_hit;
    up_lo  = tune_q && !hi_hit && lo_hit;

    hi_sum = {1'b0, rdata.tuned_high} + {1'b0, v_q};
    x_next = (XW'(rdata.tuned_low) << 3) + XW'(rdata.tuned_low) + XW'(v_q);

    calc_next = rdata;
    if (up_hi) begin
      calc_next.tuned_high = hi_sum[SB:1];
    end
    changed_next = 1'b0;
    if (rdata.pressed && (v_c < rel_c)) begin
      calc_next.pressed = 1'b0;
      changed_next      = 1'b1;
    end else if (!rdata.pressed && (v_c > act_c)) begin
      calc_next.pressed = 1'b1;
      changed_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      calc_word <= calc_next;
      lo_upd_q  <= up_lo;
      changed_q <= changed_next;
      x_q       <= x_next;
      prod_q    <= PW'(x_next) * PW'(RECIP);
    end
  end

  // divide by ten: reciprocal estimate is low by at most one
  always_comb begin
    q0     = prod_q[PW-1:XW];
    ten_q0 = (q0 << 3) + (q0 << 1);
    rem    = x_q - ten_q0;
    q_fix  = q0 + XW'(rem >= DIVISOR);

    samp_word = calc_word;
    if (lo_upd_q) begin
      samp_word.tuned_low = q_fix[SB-1:0];
    end
  end

  // table-wide update for recompute, defaults and power-up
  always_comb begin
    lo_s      = SW'(rdata.tuned_low);
    sum_act   = lo_s + SW'(cfg.act_margin);
    sum_rel   = lo_s + SW'(cfg.rel_margin);
    recomp_ok = (CMP_W'(rdata.tuned_high) > CMP_W'(cfg.high_floor)) &&
                (CMP_W'(rdata.tuned_low) > CMP_W'(cfg.low_floor));
    sweep_word = rdata;
    case (cmd.mode)
      MODE_RECOMPUTE: begin
        if (recomp_ok) begin
          sweep_word.act_level = sum_act[LVL_W-1:0];
          sweep_word.rel_level = sum_rel[LVL_W-1:0];
        end
      end
      MODE_DEFAULTS: begin
        sweep_word.act_level  = LVL_W'(cfg.actuation_default);
        sweep_word.rel_level  = LVL_W'(cfg.release_default);
        sweep_word.tuned_low  = SB'(cfg.low_floor);
        sweep_word.tuned_high = SB'(cfg.actuation_default);
      end
      MODE_RESET: begin
        sweep_word.pressed    = 1'b0;
        sweep_word.act_level  = LVL_W'(RST_ACTUATION_DEFAULT);
        sweep_word.rel_level  = LVL_W'(RST_RELEASE_DEFAULT);
        sweep_word.tuned_low  = SB'(RST_LOW_FLOOR);
        sweep_word.tuned_high = SB'(RST_ACTUATION_DEFAULT);
      end
      default: ;
    endcase
  end

  assign wdata = cmd.sample_wr ? samp_word : sweep_word;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.kind)
        EMIT_KEY: begin
          rsp_row     <= row_q;
          rsp_col     <= col_q;
          rsp_pressed <= calc_word.pressed;
          rsp_changed <= changed_q;
        end
        EMIT_ECHO: begin
          rsp_row     <= row_q;
          rsp_col     <= col_q;
          rsp_pressed <= 1'b0;
          rsp_changed <= 1'b0;
        end
        default: begin
          rsp_row     <= '0;
          rsp_col     <= '0;
          rsp_pressed <= 1'b0;
          rsp_changed <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ src/ec_key_hysteresis_autotune_core.sv @@
// Key sample: the item passes the read, tune/compare and divide-and-write steps
//   in that order, on the single key table port pair.
// Recompute and reload: every table entry is read and written back before the result.
// Results sit in an output register, so the next item is taken while one waits.
// Reset (rst, synchronous): control and configuration registers take defaults, then a
//   table init pass runs with ready low; configuration writes are still taken.
module ec_key_hysteresis_autotune_core import ekh_pkg::*; #(
  parameter int ROWS        = 8,
  parameter int COLS        = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  ekh_req_if.sink            req,
  ekh_rsp_if.source          rsp
);

  localparam int NKEYS = ROWS * COLS;
  localparam int AW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  cfg_t          cfg;
  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] sweep_addr;
  logic          req_ready;

  assign pready    = 1'b1;
  assign req.ready = req_ready;

  ekh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ekh_ctrl #(
    .NKEYS (NKEYS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req_ready),
    .sts        (sts),
    .cmd        (cmd),
    .sweep_addr (sweep_addr)
  );

  ekh_dp #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sweep_addr  (sweep_addr),
    .sts         (sts),
    .req_op      (req.op),
    .req_row     (req.key_row),
    .req_col     (req.key_col),
    .req_sample  (req.sample),
    .req_tune    (req.tune_enable),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_row     (rsp.out_row),
    .rsp_col     (rsp.out_col),
    .rsp_pressed (rsp.pressed),
    .rsp_changed (rsp.changed)
  );

endmodule

@@ bench/ec_key_hysteresis_autotune_core_tb.sv @@
module ec_key_hysteresis_autotune_core_tb import ekh_pkg::*; ();

  localparam int NROWS          = 8;
  localparam int NCOLS          = 16;
  localparam int NKEYS          = NROWS * NCOLS;
  localparam int LEVEL_MAX      = (1 << IN_SMP_W) - 1;
  localparam int HOT_KEYS       = 6;
  localparam int IDLE_PCT       = 13;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [IN_SMP_W-1:0] level;
    logic                tune;
  } key_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             pressed;
    logic             changed;
  } key_report_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ekh_req_if req_bus ();
  ekh_rsp_if rsp_bus ();

  ec_key_hysteresis_autotune_core #(
    .ROWS       (NROWS),
    .COLS       (NCOLS),
    .SAMPLE_BITS(IN_SMP_W)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req    (req_bus),
    .rsp    (rsp_bus)
  );

  // Key table mirror and register copy
  cfg_t                cfg;
  logic                pressed_st [NKEYS];
  logic [IN_SMP_W-1:0] base_low   [NKEYS];
  logic [IN_SMP_W-1:0] peak_high  [NKEYS];
  logic [LVL_W-1:0]    act_lvl    [NKEYS];
  logic [LVL_W-1:0]    rel_lvl    [NKEYS];

  key_cmd_t    pending_cmds[$];
  key_report_t expected_reports[$];
  key_cmd_t    on_bus;
  key_report_t got_report;
  key_report_t want_report;
  int          hot_keys[HOT_KEYS];
  int          mismatch_count;
  int          stall_cycles;
  bit          stall_free;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void reload_key_defaults();
    int i;
    for (i = 0; i < NKEYS; i++) begin
      act_lvl[i]   = {1'b0, cfg.actuation_default};
      rel_lvl[i]   = {1'b0, cfg.release_default};
      base_low[i]  = cfg.low_floor;
      peak_high[i] = cfg.actuation_default;
    end
  endfunction

  function automatic key_report_t predict_key_report(key_cmd_t c);
    key_report_t r;
    int          i;
    int          k;
    logic        st;
    logic        chg;
    r = '0;
    case (c.op)
      OP_RECOMPUTE: begin
        for (i = 0; i < NKEYS; i++) begin
          if (peak_high[i] > cfg.high_floor && base_low[i] > cfg.low_floor) begin
            act_lvl[i] = {1'b0, base_low[i]} + {1'b0, cfg.act_margin};
            rel_lvl[i] = {1'b0, base_low[i]} + {1'b0, cfg.rel_margin};
          end
        end
      end
      OP_DEFAULTS: reload_key_defaults();
      OP_SAMPLE: begin
        r.row = c.row;
        r.col = c.col;
        if (c.row < NROWS && c.col < NCOLS) begin
          k = int'(c.row) * NCOLS + int'(c.col);
          if (c.tune) begin
            if (c.level > peak_high[k] && c.level > cfg.high_floor) begin
              peak_high[k] = IN_SMP_W'(({1'b0, peak_high[k]} + {1'b0, c.level}) >> 1);
            end else if (c.level > cfg.low_floor && c.level < cfg.release_default) begin
              base_low[k] = IN_SMP_W'((9 * int'(base_low[k]) + int'(c.level)) / 10);
            end
          end
          st  = pressed_st[k];
          chg = 1'b0;
          if (st && {1'b0, c.level} < rel_lvl[k]) begin
            st  = 1'b0;
            chg = 1'b1;
          end else if (!st && {1'b0, c.level} > act_lvl[k]) begin
            st  = 1'b1;
            chg = 1'b1;
          end
          pressed_st[k] = st;
          r.pressed     = st;
          r.changed     = chg;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: present the next pending command, predict its report on acceptance
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected_reports.push_back(predict_key_report(on_bus));
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (pending_cmds.size() != 0 && (stall_free || $urandom_range(0, 99) >= IDLE_PCT)) begin
          on_bus              = pending_cmds.pop_front();
          req_bus.valid       <= 1'b1;
          req_bus.op          <= on_bus.op;
          req_bus.key_row     <= on_bus.row;
          req_bus.key_col     <= on_bus.col;
          req_bus.sample      <= on_bus.level;
          req_bus.tune_enable <= on_bus.tune;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each report transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got_report = '{rsp_bus.out_row, rsp_bus.out_col, rsp_bus.pressed, rsp_bus.changed};
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report row %0d col %0d pressed %0b changed %0b",
                   $time, got_report.row, got_report.col, got_report.pressed,
                   got_report.changed);
          mismatch_count++;
        end else begin
          want_report = expected_reports.pop_front();
          if (got_report !== want_report) begin
            $display("%0t: report mismatch: expected row %0d col %0d pressed %0b changed %0b",
                     $time, want_report.row, want_report.col, want_report.pressed,
                     want_report.changed);
            $display("%0t:                  actual row %0d col %0d pressed %0b changed %0b",
                     $time, got_report.row, got_report.col, got_report.pressed,
                     got_report.changed);
            mismatch_count++;
          end
        end
      end
      rsp_bus.ready <= stall_free || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("ec_key_hysteresis_autotune_core_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [IN_SMP_W-1:0] clamp_level(int v);
    if (v < 0) return '0;
    if (v > LEVEL_MAX) return '1;
    return IN_SMP_W'(v);
  endfunction

  function automatic void queue_cmd(logic [OP_W-1:0] op, int row, int col, int level, bit tune);
    key_cmd_t c;
    c.op    = op;
    c.row   = ROW_W'(row);
    c.col   = COL_W'(col);
    c.level = clamp_level(level);
    c.tune  = tune;
    pending_cmds.push_back(c);
  endfunction

  function automatic key_cmd_t random_key_cmd();
    key_cmd_t c;
    int       k;
    int       pick;
    int       lo;
    int       hi;
    int       jitter;
    int       lvl;
    pick   = $urandom_range(0, 199);
    jitter = $urandom_range(0, 8);
    k = ($urandom_range(0, 99) < 85) ? hot_keys[$urandom_range(0, HOT_KEYS - 1)]
                                     : $urandom_range(0, NKEYS - 1);
    c.row  = ROW_W'(k / NCOLS);
    c.col  = COL_W'(k % NCOLS);
    c.tune = ($urandom_range(0, 9) < 7);
    if (pick < 6) c.op = OP_RECOMPUTE;
    else if (pick < 9) c.op = OP_DEFAULTS;
    else if (pick < 12) c.op = OP_UNUSED;
    else c.op = OP_SAMPLE;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // idle window: drives the baseline average
        lo = int'(cfg.low_floor) + 1;
        hi = int'(cfg.release_default) - 1;
        if (hi < lo) hi = lo;
        lvl = $urandom_range(hi, lo);
      end
      3, 4: begin
        lo  = int'(cfg.high_floor) + 1;
        lvl = (lo > LEVEL_MAX) ? LEVEL_MAX : $urandom_range(LEVEL_MAX, lo);
      end
      5, 6: lvl = int'(act_lvl[k]) + jitter - 4;
      7:    lvl = int'(rel_lvl[k]) + jitter - 4;
      8:    lvl = $urandom_range(0, LEVEL_MAX);
      default: lvl = $urandom_range(0, 1) ? LEVEL_MAX : 0;
    endcase
    c.level = clamp_level(lvl);
    return c;
  endfunction

  function automatic cfg_t random_sane_cfg();
    cfg_t n;
    n.low_floor         = CFG_W'($urandom_range(50, 600));
    n.release_default   = n.low_floor + CFG_W'($urandom_range(40, 400));
    n.actuation_default = n.release_default + CFG_W'($urandom_range(1, 200));
    n.high_floor        = CFG_W'($urandom_range(800, 3000));
    n.act_margin        = CFG_W'($urandom_range(0, 300));
    n.rel_margin        = CFG_W'($urandom_range(0, 300));
    return n;
  endfunction

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOW_FLOOR:         cfg.low_floor         = val;
      REG_HIGH_FLOOR:        cfg.high_floor        = val;
      REG_RELEASE_DEFAULT:   cfg.release_default   = val;
      REG_ACTUATION_DEFAULT: cfg.actuation_default = val;
      REG_ACT_MARGIN:        cfg.act_margin        = val;
      REG_REL_MARGIN:        cfg.rel_margin        = val;
      default: ;
    endcase
  endtask

  // Hold until every command is reported, then let a full table sweep finish
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || req_bus.valid || expected_reports.size() != 0);
    repeat (NKEYS + 8) @(posedge clk);
  endtask

  task automatic run_phase(input cfg_t n, input int count, input bit quiet);
    int i;
    wait_idle();
    reg_write(REG_LOW_FLOOR, n.low_floor);
    reg_write(REG_HIGH_FLOOR, n.high_floor);
    reg_write(REG_RELEASE_DEFAULT, n.release_default);
    reg_write(REG_ACTUATION_DEFAULT, n.actuation_default);
    reg_write(REG_ACT_MARGIN, n.act_margin);
    reg_write(REG_REL_MARGIN, n.rel_margin);
    reg_write($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, CFG_W'($urandom));
    for (i = 0; i < HOT_KEYS; i++) hot_keys[i] = $urandom_range(0, NKEYS - 1);
    stall_free = quiet;
    if ($urandom_range(0, 1)) queue_cmd(OP_DEFAULTS, 0, 0, 0, 1'b0);
    // feed in small batches so level aiming follows the tracked table
    for (i = 0; i < count; i++) begin
      while (pending_cmds.size() > 4) @(posedge clk);
      pending_cmds.push_back(random_key_cmd());
    end
  endtask

  initial begin
    cfg_t ext;
    int   i;
    clk                 = 1'b0;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_bus.valid       = 1'b0;
    req_bus.op          = OP_SAMPLE;
    req_bus.key_row     = '0;
    req_bus.key_col     = '0;
    req_bus.sample      = '0;
    req_bus.tune_enable = 1'b0;
    rsp_bus.ready       = 1'b0;
    mismatch_count      = 0;
    stall_free          = 1'b0;
    cfg.low_floor         = RST_LOW_FLOOR;
    cfg.high_floor        = RST_HIGH_FLOOR;
    cfg.release_default   = RST_RELEASE_DEFAULT;
    cfg.actuation_default = RST_ACTUATION_DEFAULT;
    cfg.act_margin        = RST_ACT_MARGIN;
    cfg.rel_margin        = RST_REL_MARGIN;
    for (i = 0; i < NKEYS; i++) pressed_st[i] = 1'b0;
    reload_key_defaults();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // let the table init pass run
    repeat (NKEYS + 8) @(posedge clk);

    // press exactly above actuation, release exactly below release
    queue_cmd(OP_SAMPLE, 0, 0, 0, 1'b1);
    queue_cmd(OP_SAMPLE, 0, 0, 551, 1'b0);
    queue_cmd(OP_SAMPLE, 0, 0, 550, 1'b0);
    queue_cmd(OP_SAMPLE, 0, 0, 500, 1'b1);
    queue_cmd(OP_SAMPLE, 0, 0, 499, 1'b1);
    queue_cmd(OP_SAMPLE, 0, 0, 550, 1'b0);
    // peak tracking at the top of the range and at the high floor
    queue_cmd(OP_SAMPLE, 7, 15, LEVEL_MAX, 1'b1);
    queue_cmd(OP_SAMPLE, 7, 15, 1000, 1'b1);
    queue_cmd(OP_SAMPLE, 7, 15, 1001, 1'b1);
    queue_cmd(OP_SAMPLE, 7, 15, 0, 1'b1);
    // train one key so a recompute moves its thresholds
    queue_cmd(OP_SAMPLE, 3, 9, 499, 1'b1);
    queue_cmd(OP_SAMPLE, 3, 9, 499, 1'b1);
    queue_cmd(OP_SAMPLE, 3, 9, 499, 1'b1);
    queue_cmd(OP_SAMPLE, 3, 9, 300, 1'b1);
    queue_cmd(OP_SAMPLE, 3, 9, LEVEL_MAX, 1'b1);
    queue_cmd(OP_SAMPLE, 3, 9, LEVEL_MAX, 1'b1);
    queue_cmd(OP_SAMPLE, 3, 9, 0, 1'b0);
    queue_cmd(OP_RECOMPUTE, 0, 0, 0, 1'b0);
    queue_cmd(OP_SAMPLE, 3, 9, 424, 1'b0);
    queue_cmd(OP_SAMPLE, 3, 9, 403, 1'b0);
    queue_cmd(OP_SAMPLE, 3, 9, 402, 1'b0);
    // unused code with every field set returns an all-zero report
    queue_cmd(OP_UNUSED, 7, 15, LEVEL_MAX, 1'b1);
    queue_cmd(OP_SAMPLE, 3, 9, LEVEL_MAX, 1'b0);
    queue_cmd(OP_DEFAULTS, 5, 3, 1234, 1'b1);
    queue_cmd(OP_SAMPLE, 3, 9, 424, 1'b0);

    for (i = 0; i < HOT_KEYS; i++) hot_keys[i] = $urandom_range(0, NKEYS - 1);
    for (i = 0; i < 300; i++) begin
      while (pending_cmds.size() > 4) @(posedge clk);
      pending_cmds.push_back(random_key_cmd());
    end

    run_phase(random_sane_cfg(), 350, 1'b1);

    ext = '{low_floor: '0, high_floor: '0, release_default: '1, actuation_default: '1,
            act_margin: '1, rel_margin: '1};
    run_phase(ext, 300, 1'b0);
    run_phase('0, 250, 1'b0);
    run_phase('1, 250, 1'b0);
    run_phase(random_sane_cfg(), 400, 1'b0);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("ec_key_hysteresis_autotune_core_tb OK");
    end else begin
      $display("ec_key_hysteresis_autotune_core_tb NOT OK");
    end
    $finish;
  end

endmodule
